[hdl/slm_pkg.sv]
// Shared types and constants for the section latency monitor.
// Request and status codes, per-slot statistics record and its cleared value.
// No dependencies.
package slm_pkg;

	localparam int TAG_W  = 16;
	localparam int TS_W   = 48;
	localparam int SUM_W  = 64;
	localparam int MAX_W  = 49;
	localparam int CNT_W  = 32;
	localparam int SEL_W  = 4;
	localparam int STAT_W = 3;

	localparam logic [1:0] REQ_BEGIN = 2'd0;
	localparam logic [1:0] REQ_END   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
	localparam logic [STAT_W-1:0] ST_DOUBLE_BEGIN = 3'd1;
	localparam logic [STAT_W-1:0] ST_END_NO_BEGIN = 3'd2;
	localparam logic [STAT_W-1:0] ST_UNKNOWN_TAG  = 3'd3;
	localparam logic [STAT_W-1:0] ST_TABLE_FULL   = 3'd4;
	localparam logic [STAT_W-1:0] ST_SLOT_UNUSED  = 3'd5;

	localparam logic [TS_W-1:0]  MIN_NONE = 48'd2147483647;
	localparam logic [MAX_W-1:0] MAX_NONE = {MAX_W{1'b1}};

	typedef struct packed {
		logic [SUM_W-1:0]        sum;
		logic [TS_W-1:0]         min1;
		logic [TS_W-1:0]         min2;
		logic signed [MAX_W-1:0] max1;
		logic signed [MAX_W-1:0] max2;
		logic [CNT_W-1:0]        cnt;
	} stats_t;

	localparam stats_t STATS_CLR = '{
		sum:  '0,
		min1: MIN_NONE,
		min2: MIN_NONE,
		max1: MAX_NONE,
		max2: MAX_NONE,
		cnt:  '0
	};

endpackage

[hdl/slm_tag_cam.sv]
// Tag store with parallel match: registered hit and free vectors,
// lowest-index encode of both. Depends on slm_pkg.
module slm_tag_cam
	import slm_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int IW    = 4
) (
	input  logic             clk,
	input  logic             cmp_en,
	input  logic [TAG_W-1:0] cmp_tag,
	input  logic [SLOTS-1:0] used,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_idx,
	input  logic [TAG_W-1:0] wr_tag,
	input  logic [IW-1:0]    rd_idx,
	output logic [TAG_W-1:0] rd_tag,
	output logic             hit,
	output logic [IW-1:0]    hit_idx,
	output logic             free,
	output logic [IW-1:0]    free_idx
);

	logic [TAG_W-1:0] tags_q [SLOTS];
	logic [SLOTS-1:0] hit_vec_q;
	logic [SLOTS-1:0] free_vec_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tags_q[wr_idx] <= wr_tag;
		end
	end

	// match vector is taken on the accept edge and encoded combinationally in the next cycle
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			for (int i = 0; i < SLOTS; i++) begin
				hit_vec_q[i] <= used[i] && (tags_q[i] == cmp_tag);
			end
			free_vec_q <= ~used;
		end
	end

	always_comb begin
		hit      = |hit_vec_q;
		free     = |free_vec_q;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec_q[i]) begin
				hit_idx = IW'(i);
			end
			if (free_vec_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign rd_tag = tags_q[rd_idx];

endmodule

[hdl/section_latency_monitor.sv]
// Section latency monitor: one request word in, one result word out.
// The result word is registered after these steps in order: tag match is
// captured on the accept edge, then memory read, elapsed subtract, update/write-back.
// A new word is taken only once the current one has finished its slot read-modify-write.
// A result word held by m_tready stalls the update step and the input with it.
// Reset: slot used/open flags and statistics-valid bits clear at once, no sweep.
module section_latency_monitor
	import slm_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tag[15:0], timestamp[63:16], slot_select[67:64], zero pad
	input  logic [71:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slot_index[3:0], elapsed[51:4], slot_tag[67:52], total_time[131:68],
	// min_first[179:132], min_second[227:180], max_first[276:228],
	// max_second[325:277], call_count[357:326], zero pad
	output logic [359:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_ELAP = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0]       state_q;
	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] open_q;
	logic [SLOTS-1:0] stv_q;

	logic [1:0]       req_q;
	logic [TAG_W-1:0] tag_q;
	logic [TS_W-1:0]  ts_q;
	logic [SEL_W-1:0] sel_q;

	logic [IW-1:0]     s_q;
	logic              ok_q;
	logic              claim_q;
	logic [STAT_W-1:0] status_q;

	logic [TS_W-1:0] start_mem [SLOTS];
	stats_t          stats_mem [SLOTS];
	logic [TS_W-1:0] start_rd_q;
	stats_t          stats_rd_q;
	logic [TS_W-1:0] el_q;
	stats_t          cur_q;

	logic              in_acc;
	logic              out_busy;
	logic              upd_go;
	logic              cam_hit;
	logic              cam_free;
	logic [IW-1:0]     cam_hit_idx;
	logic [IW-1:0]     cam_free_idx;
	logic [TAG_W-1:0]  cam_rd_tag;
	logic [IW-1:0]     s_d;
	logic              ok_d;
	logic              claim_d;
	logic [STAT_W-1:0] status_d;
	logic              sel_ok;
	logic [IW-1:0]     sel_idx;
	stats_t            nxt;
	logic [7:0]        s_wide;
	logic              is_end;
	logic              wr_slot;

	logic              mv_q;
	logic [STAT_W-1:0] o_status_q;
	logic [3:0]        o_idx_q;
	logic [TS_W-1:0]   o_el_q;
	logic [TAG_W-1:0]  o_tag_q;
	stats_t            o_st_q;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_busy = mv_q && !m_tready;
	assign upd_go   = (state_q == S_UPD) && !out_busy;

	slm_tag_cam #(
		.SLOTS(SLOTS),
		.IW   (IW)
	) u_cam (
		.clk     (clk),
		.cmp_en  (in_acc),
		.cmp_tag (s_tdata[15:0]),
		.used    (used_q),
		.wr_en   (upd_go && claim_q),
		.wr_idx  (s_q),
		.wr_tag  (tag_q),
		.rd_idx  (s_q),
		.rd_tag  (cam_rd_tag),
		.hit     (cam_hit),
		.hit_idx (cam_hit_idx),
		.free    (cam_free),
		.free_idx(cam_free_idx)
	);

	assign sel_idx = IW'(sel_q);
	assign sel_ok  = (32'(sel_q) < SLOTS) && used_q[sel_idx];

	always_comb begin
		s_d      = '0;
		ok_d     = 1'b0;
		claim_d  = 1'b0;
		status_d = ST_OK;
		unique case (req_q)
			REQ_BEGIN: begin
				if (cam_hit) begin
					s_d      = cam_hit_idx;
					ok_d     = 1'b1;
					status_d = open_q[cam_hit_idx] ? ST_DOUBLE_BEGIN : ST_OK;
				end else if (cam_free) begin
					s_d     = cam_free_idx;
					ok_d    = 1'b1;
					claim_d = 1'b1;
				end else begin
					status_d = ST_TABLE_FULL;
				end
			end
			REQ_END: begin
				if (cam_hit) begin
					s_d      = cam_hit_idx;
					ok_d     = 1'b1;
					status_d = open_q[cam_hit_idx] ? ST_OK : ST_END_NO_BEGIN;
				end else begin
					status_d = ST_UNKNOWN_TAG;
				end
			end
			REQ_CLEAR: begin
				status_d = ST_OK;
			end
			REQ_READ: begin
				if (sel_ok) begin
					s_d  = sel_idx;
					ok_d = 1'b1;
				end else begin
					status_d = ST_SLOT_UNUSED;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= s_tuser;
			tag_q <= s_tdata[15:0];
			ts_q  <= s_tdata[63:16];
			sel_q <= s_tdata[67:64];
		end
		if (state_q == S_LOOK) begin
			s_q        <= s_d;
			ok_q       <= ok_d;
			claim_q    <= claim_d;
			status_q   <= status_d;
			start_rd_q <= start_mem[s_d];
			stats_rd_q <= stats_mem[s_d];
		end
		if (state_q == S_ELAP) begin
			el_q  <= ts_q - start_rd_q;
			// statistics wiped by a clear or never written read as cleared
			cur_q <= (stv_q[s_q] && !claim_q) ? stats_rd_q : STATS_CLR;
		end
	end

	assign is_end  = (req_q == REQ_END);
	assign wr_slot = ok_q && ((req_q == REQ_BEGIN) || is_end);

	always_comb begin
		nxt = cur_q;
		if (is_end) begin
			nxt.sum = cur_q.sum + SUM_W'(el_q);
			nxt.cnt = cur_q.cnt + CNT_W'(1);
			if (el_q < cur_q.min1) begin
				nxt.min2 = cur_q.min1;
				nxt.min1 = el_q;
			end else if (el_q < cur_q.min2) begin
				nxt.min2 = el_q;
			end
			if ($signed({1'b0, el_q}) > $signed(cur_q.max1)) begin
				nxt.max2 = cur_q.max1;
				nxt.max1 = {1'b0, el_q};
			end else if ($signed({1'b0, el_q}) > $signed(cur_q.max2)) begin
				nxt.max2 = {1'b0, el_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && wr_slot) begin
			stats_mem[s_q] <= nxt;
		end
		if (upd_go && ok_q && (req_q == REQ_BEGIN)) begin
			start_mem[s_q] <= ts_q;
		end
	end

	assign s_wide = 8'(s_q);

	// output word register
	always_ff @(posedge clk) begin
		if (upd_go) begin
			o_status_q <= status_q;
			o_idx_q    <= ok_q ? s_wide[3:0] : ((req_q == REQ_READ) ? sel_q : 4'd0);
			o_el_q     <= (ok_q && is_end) ? el_q : '0;
			o_tag_q    <= ok_q ? ((req_q == REQ_READ) ? cam_rd_tag : tag_q) : '0;
			o_st_q     <= ok_q ? nxt : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			open_q  <= '0;
			stv_q   <= '0;
			mv_q    <= 1'b0;
		end else begin
			if (m_tready && !upd_go) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_ELAP;
				end
				S_ELAP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
						mv_q    <= 1'b1;
						if (req_q == REQ_CLEAR) begin
							stv_q <= '0;
						end
						if (wr_slot) begin
							stv_q[s_q]  <= 1'b1;
							open_q[s_q] <= (req_q == REQ_BEGIN);
						end
						if (claim_q) begin
							used_q[s_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {2'b00, o_st_q.cnt, o_st_q.max2, o_st_q.max1, o_st_q.min2,
		o_st_q.min1, o_st_q.sum, o_tag_q, o_el_q, o_idx_q};

`ifndef SYNTHESIS
	a_open_implies_used: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q & ~used_q) == '0)
		else $error("open slot that is not in use");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_UPD))
		else $error("result word raised outside the update step");

	a_full_means_all_used: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_tvalid) && (m_tuser == ST_TABLE_FULL)) |-> (&used_q))
		else $error("table full reported with a free slot");

	a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_LOOK))
		else $error("accepted word did not start a lookup");
`endif

endmodule
